// ===== sv/etrm_pkg.sv =====
package etrm_pkg;

   localparam int FRAC_INT = 28;
   localparam int ZW = 33;
   localparam int XW = 32;
   localparam int ATAN_LEN = 24;
   localparam int QW = 18;

   localparam logic signed [ZW-1:0] PI_Q      = 33'sd843314857;
   localparam logic signed [ZW-1:0] TWO_PI_Q  = 33'sd1686629713;
   localparam logic signed [ZW-1:0] HALF_PI_Q = 33'sd421657428;
   localparam logic signed [XW-1:0] GAIN_Q    = 32'sd163008219;
   localparam logic signed [QW-1:0] ONE_Q16   = 18'sd65536;

   typedef logic signed [QW-1:0] q16_type;

   typedef struct packed {
      q16_type s;
      q16_type c;
   } sincos_type;

   function automatic logic signed [ZW-1:0] atan_value(input int i);
      logic signed [ZW-1:0] r;
      case (i)
         0:  r = 33'sd210828714;
         1:  r = 33'sd124459457;
         2:  r = 33'sd65760959;
         3:  r = 33'sd33381290;
         4:  r = 33'sd16755422;
         5:  r = 33'sd8385879;
         6:  r = 33'sd4193963;
         7:  r = 33'sd2097109;
         8:  r = 33'sd1048571;
         9:  r = 33'sd524287;
         10: r = 33'sd262144;
         11: r = 33'sd131072;
         12: r = 33'sd65536;
         13: r = 33'sd32768;
         14: r = 33'sd16384;
         15: r = 33'sd8192;
         16: r = 33'sd4096;
         17: r = 33'sd2048;
         18: r = 33'sd1024;
         19: r = 33'sd512;
         20: r = 33'sd256;
         21: r = 33'sd128;
         22: r = 33'sd64;
         23: r = 33'sd32;
         default: r = '0;
      endcase
      return r;
   endfunction

   // round a Q3.16 x Q3.16 product back to Q3.16
   function automatic logic signed [QW+1:0] qmul(input logic signed [QW+1:0] a,
                                                 input logic signed [QW+1:0] b);
      logic signed [2*QW+3:0] p;
      p = a * b + 40'sd32768;
      return p[QW+17:16];
   endfunction

   function automatic q16_type clamp_one(input logic signed [QW+1:0] v);
      q16_type r;
      if (v > 20'sd65536) r = ONE_Q16;
      else if (v < -20'sd65536) r = -ONE_Q16;
      else r = v[QW-1:0];
      return r;
   endfunction

endpackage

// ===== sv/etrm_sincos.sv =====
// Pipelined sine/cosine: two stages of range reduction, one stage per
// CORDIC step, one output rounding stage.
module etrm_sincos #(
   parameter int ANGLE_WIDTH = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic signed [ANGLE_WIDTH-1:0] angle,
   output etrm_pkg::sincos_type          result
);

   localparam int ZW = etrm_pkg::ZW;
   localparam int XW = etrm_pkg::XW;
   localparam int NS = (CORDIC_STEPS < etrm_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                            : etrm_pkg::ATAN_LEN;
   localparam int SH = etrm_pkg::FRAC_INT - (ANGLE_WIDTH - 4);

   // stage 0: widen and reduce modulo two pi
   logic signed [ZW-1:0] z0_ff, z0_in;
   // stage 1: fold into half range
   logic signed [ZW-1:0] z1_ff, z1_in;
   logic flip1_ff, flip1_in;

   always_comb begin
      logic signed [ZW-1:0] z;
      z = ZW'(angle) <<< SH;
      for (int k = 0; k < 3; k++) begin
         if (z > etrm_pkg::PI_Q) z = z - etrm_pkg::TWO_PI_Q;
         else if (z < -etrm_pkg::PI_Q) z = z + etrm_pkg::TWO_PI_Q;
      end
      z0_in = z;
   end

   always_comb begin
      z1_in = z0_ff;
      flip1_in = 1'b0;
      if (z0_ff > etrm_pkg::HALF_PI_Q) begin
         z1_in = z0_ff - etrm_pkg::PI_Q;
         flip1_in = 1'b1;
      end else if (z0_ff < -etrm_pkg::HALF_PI_Q) begin
         z1_in = z0_ff + etrm_pkg::PI_Q;
         flip1_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      z0_ff <= z0_in;
      z1_ff <= z1_in;
      flip1_ff <= flip1_in;
   end

   logic signed [XW-1:0] x_ff [0:NS];
   logic signed [XW-1:0] y_ff [0:NS];
   logic signed [ZW-1:0] z_ff [0:NS];
   logic                 f_ff [0:NS];

   always_comb begin
      x_ff[0] = etrm_pkg::GAIN_Q;
      y_ff[0] = '0;
      z_ff[0] = z1_ff;
      f_ff[0] = flip1_ff;
   end

   for (genvar i = 0; i < NS; i++) begin : g_step
      logic signed [XW-1:0] x_in, y_in;
      logic signed [ZW-1:0] z_in;
      always_comb begin
         if (z_ff[i] >= 0) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - etrm_pkg::atan_value(i);
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + etrm_pkg::atan_value(i);
         end
      end
      always_ff @(posedge clock) begin
         x_ff[i+1] <= x_in;
         y_ff[i+1] <= y_in;
         z_ff[i+1] <= z_in;
         f_ff[i+1] <= f_ff[i];
      end
   end

   etrm_pkg::sincos_type result_ff, result_in;

   always_comb begin
      logic signed [XW-1:0] xr, yr;
      etrm_pkg::q16_type xc, yc;
      xr = (x_ff[NS] + 32'sd2048) >>> 12;
      yr = (y_ff[NS] + 32'sd2048) >>> 12;
      xc = etrm_pkg::clamp_one(xr[19:0]);
      yc = etrm_pkg::clamp_one(yr[19:0]);
      if (xr > 32'sd65536) xc = etrm_pkg::ONE_Q16;
      if (yr > 32'sd65536) yc = etrm_pkg::ONE_Q16;
      if (xr < -32'sd65536) xc = -etrm_pkg::ONE_Q16;
      if (yr < -32'sd65536) yc = -etrm_pkg::ONE_Q16;
      result_in.c = f_ff[NS] ? -xc : xc;
      result_in.s = f_ff[NS] ? -yc : yc;
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== sv/etrm_matrix.sv =====
// Three-stage product network: pairwise products, triple products, sums.
module etrm_matrix (
   input  logic                 clock,
   input  etrm_pkg::sincos_type sc_x,
   input  etrm_pkg::sincos_type sc_y,
   input  etrm_pkg::sincos_type sc_z,
   output etrm_pkg::q16_type    m00,
   output etrm_pkg::q16_type    m01,
   output etrm_pkg::q16_type    m02,
   output etrm_pkg::q16_type    m10,
   output etrm_pkg::q16_type    m11,
   output etrm_pkg::q16_type    m12,
   output etrm_pkg::q16_type    m20,
   output etrm_pkg::q16_type    m21,
   output etrm_pkg::q16_type    m22
);

   typedef logic signed [19:0] w_type;

   // stage A
   w_type cycz_ff, sysz_ff, cysz_ff, czsy_ff, msycx_ff, mcxsz_ff, cxcz_ff, cycx_ff;
   w_type sxa_ff;
   always_ff @(posedge clock) begin
      cycz_ff  <= etrm_pkg::qmul(20'(sc_y.c), 20'(sc_z.c));
      sysz_ff  <= etrm_pkg::qmul(20'(sc_y.s), 20'(sc_z.s));
      cysz_ff  <= etrm_pkg::qmul(20'(sc_y.c), 20'(sc_z.s));
      czsy_ff  <= etrm_pkg::qmul(20'(sc_z.c), 20'(sc_y.s));
      msycx_ff <= etrm_pkg::qmul(-20'(sc_y.s), 20'(sc_x.c));
      mcxsz_ff <= etrm_pkg::qmul(-20'(sc_x.c), 20'(sc_z.s));
      cxcz_ff  <= etrm_pkg::qmul(20'(sc_x.c), 20'(sc_z.c));
      cycx_ff  <= etrm_pkg::qmul(20'(sc_y.c), 20'(sc_x.c));
      sxa_ff   <= 20'(sc_x.s);
   end

   // stage B
   w_type t0_ff, t1_ff, t6_ff, t7_ff;
   w_type cycz_b_ff, cysz_b_ff, czsy_b_ff, sysz_b_ff;
   w_type m02_b_ff, m10_b_ff, m11_b_ff, m22_b_ff, sx_b_ff;
   always_ff @(posedge clock) begin
      t0_ff <= etrm_pkg::qmul(sysz_ff, sxa_ff);
      t1_ff <= etrm_pkg::qmul(czsy_ff, sxa_ff);
      t6_ff <= etrm_pkg::qmul(cysz_ff, sxa_ff);
      t7_ff <= etrm_pkg::qmul(cycz_ff, sxa_ff);
      cycz_b_ff <= cycz_ff;
      cysz_b_ff <= cysz_ff;
      czsy_b_ff <= czsy_ff;
      sysz_b_ff <= sysz_ff;
      m02_b_ff <= msycx_ff;
      m10_b_ff <= mcxsz_ff;
      m11_b_ff <= cxcz_ff;
      m22_b_ff <= cycx_ff;
      sx_b_ff <= sxa_ff;
   end

   // stage C: sums and saturation
   etrm_pkg::q16_type o_ff [0:8];
   always_ff @(posedge clock) begin
      o_ff[0] <= etrm_pkg::clamp_one(cycz_b_ff - t0_ff);
      o_ff[1] <= etrm_pkg::clamp_one(cysz_b_ff + t1_ff);
      o_ff[2] <= etrm_pkg::clamp_one(m02_b_ff);
      o_ff[3] <= etrm_pkg::clamp_one(m10_b_ff);
      o_ff[4] <= etrm_pkg::clamp_one(m11_b_ff);
      o_ff[5] <= etrm_pkg::clamp_one(sx_b_ff);
      o_ff[6] <= etrm_pkg::clamp_one(czsy_b_ff + t6_ff);
      o_ff[7] <= etrm_pkg::clamp_one(sysz_b_ff - t7_ff);
      o_ff[8] <= etrm_pkg::clamp_one(m22_b_ff);
   end

   assign m00 = o_ff[0];
   assign m01 = o_ff[1];
   assign m02 = o_ff[2];
   assign m10 = o_ff[3];
   assign m11 = o_ff[4];
   assign m12 = o_ff[5];
   assign m20 = o_ff[6];
   assign m21 = o_ff[7];
   assign m22 = o_ff[8];

endmodule

// ===== sv/euler_to_rotation_matrix.sv =====
// Euler angles to 3x3 rotation matrix. Accepts one angle triple per clock
// (busy stays low). The pipeline has min(CORDIC_STEPS, 24) + 6 register stages:
// two reduction stages, one stage per CORDIC step capped at 24, one rounding
// stage and three product/sum stages. The first stage loads at the accepting
// edge, and rsp_valid is driven with the matrix when the last stage loads. The
// CORDIC chain sets the depth. The receiver cannot stall; each result is shown
// for one cycle.
module euler_to_rotation_matrix #(
   parameter int ANGLE_WIDTH = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle_x,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle_y,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle_z,
   output logic                          rsp_valid,
   output logic signed [17:0]            rsp_m00,
   output logic signed [17:0]            rsp_m01,
   output logic signed [17:0]            rsp_m02,
   output logic signed [17:0]            rsp_m10,
   output logic signed [17:0]            rsp_m11,
   output logic signed [17:0]            rsp_m12,
   output logic signed [17:0]            rsp_m20,
   output logic signed [17:0]            rsp_m21,
   output logic signed [17:0]            rsp_m22
);

   localparam int NS = (CORDIC_STEPS < etrm_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                            : etrm_pkg::ATAN_LEN;
   localparam int LAT = NS + 6;

   etrm_pkg::sincos_type sc_x, sc_y, sc_z;

   assign busy = 1'b0;

   etrm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_x (
      .clock(clock), .angle(req_angle_x), .result(sc_x));
   etrm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_y (
      .clock(clock), .angle(req_angle_y), .result(sc_y));
   etrm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_z (
      .clock(clock), .angle(req_angle_z), .result(sc_z));

   etrm_matrix u_matrix (
      .clock(clock), .sc_x(sc_x), .sc_y(sc_y), .sc_z(sc_z),
      .m00(rsp_m00), .m01(rsp_m01), .m02(rsp_m02),
      .m10(rsp_m10), .m11(rsp_m11), .m12(rsp_m12),
      .m20(rsp_m20), .m21(rsp_m21), .m22(rsp_m22));

   // request valid bits travel alongside the data
   logic [LAT-1:0] valid_ff, valid_in;

   always_comb begin
      valid_in = {valid_ff[LAT-2:0], start & ~busy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[LAT-1];

`ifndef SYNTHESIS
   a_lat: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> ##(LAT-1) rsp_valid)
      else $error("request lost in pipeline");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_m00 <= 18'sd65536 && rsp_m00 >= -18'sd65536 &&
                     rsp_m21 <= 18'sd65536 && rsp_m21 >= -18'sd65536))
      else $error("matrix entry out of range");
   a_m12: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_m12 == $past(sc_x.s, 3)))
      else $error("m12 does not match sine of X");
`endif

endmodule

// ===== tb/tb_euler_to_rotation_matrix.sv =====
`timescale 1ns / 1ps

module tb_euler_to_rotation_matrix;

   localparam int ANGLE_WIDTH = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int LATENCY = CORDIC_STEPS + 7;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic signed [ANGLE_WIDTH-1:0] ax;
      logic signed [ANGLE_WIDTH-1:0] ay;
      logic signed [ANGLE_WIDTH-1:0] az;
   } angles_type;

   typedef struct packed {
      etrm_pkg::q16_type m00, m01, m02, m10, m11, m12, m20, m21, m22;
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [ANGLE_WIDTH-1:0] req_angle_x = '0;
   logic signed [ANGLE_WIDTH-1:0] req_angle_y = '0;
   logic signed [ANGLE_WIDTH-1:0] req_angle_z = '0;
   logic rsp_valid;
   etrm_pkg::q16_type rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   etrm_pkg::q16_type rsp_m20, rsp_m21, rsp_m22;

   angles_type pending_q[$];
   matrix_type matrix_q[$];
   int errors = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   bit hold_off = 0;
   bit accept_seen = 0;

   euler_to_rotation_matrix #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_angle_x(req_angle_x), .req_angle_y(req_angle_y), .req_angle_z(req_angle_z),
      .rsp_valid(rsp_valid),
      .rsp_m00(rsp_m00), .rsp_m01(rsp_m01), .rsp_m02(rsp_m02),
      .rsp_m10(rsp_m10), .rsp_m11(rsp_m11), .rsp_m12(rsp_m12),
      .rsp_m20(rsp_m20), .rsp_m21(rsp_m21), .rsp_m22(rsp_m22)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint floor_div(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint sat_one(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
   endfunction

   function automatic longint round_mul(longint a, longint b);
      return floor_div(a * b + 32768, 16);
   endfunction

   function automatic void angle_sincos(logic signed [ANGLE_WIDTH-1:0] a,
                                        output longint s, output longint c);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'(a) <<< (28 - (ANGLE_WIDTH - 4));
      x = 163008219;
      y = 0;
      flip = 0;
      for (int k = 0; k < 3; k++) begin
         if (z > 843314857) z -= 1686629713;
         else if (z < -843314857) z += 1686629713;
      end
      if (z > 421657428) begin
         z -= 843314857; flip = 1;
      end else if (z < -421657428) begin
         z += 843314857; flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         dx = floor_div(y, i);
         dy = floor_div(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(etrm_pkg::atan_value(i));
         end else begin
            x += dx; y -= dy; z += longint'(etrm_pkg::atan_value(i));
         end
      end
      x = sat_one(floor_div(x + 2048, 12));
      y = sat_one(floor_div(y + 2048, 12));
      if (flip) begin
         x = -x; y = -y;
      end
      s = y;
      c = x;
   endfunction

   function automatic matrix_type rotation_of(angles_type a);
      longint sx, cx, sy, cy, sz, cz;
      matrix_type m;
      angle_sincos(a.ax, sx, cx);
      angle_sincos(a.ay, sy, cy);
      angle_sincos(a.az, sz, cz);
      m.m00 = etrm_pkg::q16_type'(sat_one(round_mul(cy, cz)
                                          - round_mul(round_mul(sy, sz), sx)));
      m.m01 = etrm_pkg::q16_type'(sat_one(round_mul(cy, sz)
                                          + round_mul(round_mul(cz, sy), sx)));
      m.m02 = etrm_pkg::q16_type'(sat_one(round_mul(-sy, cx)));
      m.m10 = etrm_pkg::q16_type'(sat_one(round_mul(-cx, sz)));
      m.m11 = etrm_pkg::q16_type'(sat_one(round_mul(cx, cz)));
      m.m12 = etrm_pkg::q16_type'(sat_one(sx));
      m.m20 = etrm_pkg::q16_type'(sat_one(round_mul(cz, sy)
                                          + round_mul(round_mul(cy, sz), sx)));
      m.m21 = etrm_pkg::q16_type'(sat_one(round_mul(sy, sz)
                                          - round_mul(round_mul(cy, cz), sx)));
      m.m22 = etrm_pkg::q16_type'(sat_one(round_mul(cy, cx)));
      return m;
   endfunction

   task automatic report_mismatch(string what, etrm_pkg::q16_type got,
                                  etrm_pkg::q16_type want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 50) return 0;
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver: retire the accepted request and present the next at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else if (!start || accept_seen) begin
         if (accept_seen) begin
            matrix_q.push_back(rotation_of(pending_q.pop_front()));
            gap_left = pick_gap();
         end
         if (gap_left > 0 || hold_off || pending_q.size() == 0) begin
            if (gap_left > 0) gap_left = gap_left - 1;
            start <= 1'b0;
         end else begin
            start <= 1'b1;
            req_angle_x <= pending_q[0].ax;
            req_angle_y <= pending_q[0].ay;
            req_angle_z <= pending_q[0].az;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      matrix_type w;
      if (reset) begin
         idle_cycles <= 0;
         accept_seen <= 1'b0;
      end else begin
         accept_seen <= start && !busy;
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            if (matrix_q.size() == 0) begin
               $display("unexpected result at %0t", $realtime);
               errors++;
            end else begin
               w = matrix_q.pop_front();
               if (rsp_m00 !== w.m00) report_mismatch("m00", rsp_m00, w.m00);
               if (rsp_m01 !== w.m01) report_mismatch("m01", rsp_m01, w.m01);
               if (rsp_m02 !== w.m02) report_mismatch("m02", rsp_m02, w.m02);
               if (rsp_m10 !== w.m10) report_mismatch("m10", rsp_m10, w.m10);
               if (rsp_m11 !== w.m11) report_mismatch("m11", rsp_m11, w.m11);
               if (rsp_m12 !== w.m12) report_mismatch("m12", rsp_m12, w.m12);
               if (rsp_m20 !== w.m20) report_mismatch("m20", rsp_m20, w.m20);
               if (rsp_m21 !== w.m21) report_mismatch("m21", rsp_m21, w.m21);
               if (rsp_m22 !== w.m22) report_mismatch("m22", rsp_m22, w.m22);
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_euler_to_rotation_matrix failed");
            $finish;
         end
      end
   end

   function automatic logic signed [ANGLE_WIDTH-1:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return ANGLE_WIDTH'($urandom_range(0, 15) - 8);
         1: return $urandom_range(0, 1) ? ANGLE_WIDTH'(32'h7fff - $urandom_range(0, 7))
                                        : ANGLE_WIDTH'(32'h8000 + $urandom_range(0, 7));
         // near multiples of pi/2 in Q3.12
         2: return ANGLE_WIDTH'(6434 * ($urandom_range(0, 10) - 5) + $urandom_range(0, 8) - 4);
         default: return ANGLE_WIDTH'($urandom());
      endcase
   endfunction

   initial begin
      angles_type a;
      logic signed [ANGLE_WIDTH-1:0] corners[8];
      int drain;
      corners = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff,
                  16'sd6434, -16'sd6434, 16'sd12868};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 8; i++) begin
         a.ax = corners[i]; a.ay = corners[(i + 3) % 8]; a.az = corners[(i + 5) % 8];
         pending_q.push_back(a);
      end
      for (int i = 0; i < 8; i++) begin
         a.ax = corners[i]; a.ay = corners[i]; a.az = corners[i];
         pending_q.push_back(a);
      end
      a = '{16'sh5555, 16'shaaaa, 16'sh0f0f};
      pending_q.push_back(a);
      for (int i = 0; i < 1600; i++) begin
         a.ax = rand_angle(); a.ay = rand_angle(); a.az = rand_angle();
         pending_q.push_back(a);
         if (i == 800) begin
            // hold until the pipeline drains
            wait (pending_q.size() == 0);
            hold_off = 1;
            wait (matrix_q.size() == 0);
            hold_off = 0;
         end
      end
      wait (pending_q.size() == 0 && matrix_q.size() == 0);
      drain = 0;
      while (drain < 2 * LATENCY) begin
         @(posedge clock);
         drain++;
      end
      if (errors == 0 && matrix_q.size() == 0) begin
         $display("tb_euler_to_rotation_matrix passed");
      end else begin
         $display("tb_euler_to_rotation_matrix failed");
      end
      $finish;
   end

endmodule

// ===== euler_to_rotation_matrix.f =====
sv/etrm_pkg.sv
sv/etrm_sincos.sv
sv/etrm_matrix.sv
sv/euler_to_rotation_matrix.sv
tb/tb_euler_to_rotation_matrix.sv
